FILE: rtl/tdp_pkg.sv
// Shared types and constants for the tile dot plotter.
// Holds item codes, controller states, the command and status bundles, and the zoom shape table.
// No dependencies.
`default_nettype none

package tdp_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ZOOM_W  = 5;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned OFS_W   = 4;
  localparam int unsigned RR_W    = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PLOT  = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load_plot;
    logic load_read;
    logic clear_bump;
    logic clear_sweep;
    logic sweep_step;
    logic scan_step;
    logic read_issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic epoch_full;
    logic sweep_last;
    logic scan_last;
  } status_t;

  // Offsets are two's complement in OFS_W bits
  typedef struct packed {
    logic             draw;
    logic             disk;
    logic [OFS_W-1:0] lo;
    logic [OFS_W-1:0] hi;
    logic [RR_W-1:0]  rr;
  } shape_t;

  function automatic shape_t zoom_shape(logic [ZOOM_W-1:0] zoom);
    shape_t     s;
    logic [2:0] r;
    s = '0;
    r = 3'd4;
    case (zoom) inside
      [5'd0:5'd7]:   s.draw = 1'b0;
      5'd8, 5'd9:    s.draw = 1'b1;
      5'd10: begin
        s.draw = 1'b1;
        s.hi   = OFS_W'(1);
      end
      [5'd11:5'd13]: r = 3'd2;
      5'd14:         r = 3'd3;
      5'd15, 5'd16:  r = 3'd4;
      5'd17:         r = 3'd5;
      default:       r = 3'd4;
    endcase
    if (zoom > 5'd10) begin
      s.draw = 1'b1;
      s.disk = 1'b1;
      s.hi   = {1'b0, r};
      s.lo   = OFS_W'(-{1'b0, r});
      s.rr   = {3'b000, r} * {3'b000, r};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tile_dot_plotter_unit.sv
// Top level of the tile dot plotter: controller plus datapath.
// Depends on tdp_pkg, tdp_ctrl and tdp_datapath.
`default_nettype none

// Tile dot plotter. An item is taken at a rising edge with start high and
// busy low; kind selects clear, plot or read, and kind 3 is dropped. A read
// transfers its pixel on read_value_o for exactly one cycle, marked by
// result_valid_o, in the result state that follows its lookup state; the
// receiver cannot stall it, so sample it on that cycle. Clear and plot give
// no result. Per item, after acceptance:
//   clear: busy stays low. Clearing bumps an 8-bit epoch tag kept beside
//          every pixel; every 256th clear instead runs a sweep that zeroes
//          all SPAN*SPAN words, where SPAN = min(TILE_SIZE, 256).
//   plot : the scan visits one pixel of the dot's bounding box per cycle;
//          the box is (2r+1)^2 pixels for a disk of radius r (121 for
//          r = 5), 4 for the 2x2 block, 1 for a single pixel or an empty
//          dot. The single write port of the tile memory sets this rate.
//   read : memory lookup, then the result state. After reset the same sweep
// zeroes the memory with busy high. The user must write zoom_level (cfg_we_i,
// cfg_wdata_i) only while the unit is idle; the block does not enforce it.
module tile_dot_plotter_unit #(
  parameter int unsigned TILE_SIZE = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tdp_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [tdp_pkg::COORD_W-1:0] x_pos_i,
  input  wire logic [tdp_pkg::COORD_W-1:0] y_pos_i,
  input  wire logic [tdp_pkg::PIX_W-1:0]   pixel_value_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [tdp_pkg::ZOOM_W-1:0]  cfg_wdata_i,
  output logic                             result_valid_o,
  output logic [tdp_pkg::PIX_W-1:0]        read_value_o
);
  import tdp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each item: sweep, scan, lookup and result strobe
  tdp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (kind_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Hold the tile, the zoom register and the scan counters
  tdp_datapath #(
    .TILE_SIZE (TILE_SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .pixel_value_i (pixel_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .read_value_o  (read_value_o)
  );

endmodule

`default_nettype wire

FILE: rtl/tdp_ctrl.sv
// Sequencing controller of the tile dot plotter.
// Depends on tdp_pkg; drives the datapath through cmd_t and watches status_t.
`default_nettype none

module tdp_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire logic [tdp_pkg::KIND_W-1:0]  kind_i,
  input  wire tdp_pkg::status_t            status_i,
  output tdp_pkg::cmd_t                    cmd_o,
  output logic                             busy,
  output logic                             result_valid_o
);
  import tdp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (kind_i)
            KIND_CLEAR: if (status_i.epoch_full) state_d = ST_SWEEP;
            KIND_PLOT:  state_d = ST_SCAN;
            KIND_READ:  state_d = ST_READ;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_IDLE;
      end
      ST_READ:   state_d = ST_RESULT;
      ST_RESULT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_SWEEP: cmd_o.sweep_step = 1'b1;
      ST_IDLE: begin
        if (start) begin
          case (kind_i)
            KIND_CLEAR: begin
              cmd_o.clear_sweep = status_i.epoch_full;
              cmd_o.clear_bump  = !status_i.epoch_full;
            end
            KIND_PLOT: cmd_o.load_plot = 1'b1;
            KIND_READ: cmd_o.load_read = 1'b1;
            default:   cmd_o = '0;
          endcase
        end
      end
      ST_SCAN:   cmd_o.scan_step  = 1'b1;
      ST_READ:   cmd_o.read_issue = 1'b1;
      ST_RESULT: cmd_o.emit       = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = cmd_o.emit;

  a_result_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_READ))
    else $error("result strobe without a preceding read lookup");

  a_read_goes_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_READ) |=> (state_q == ST_READ))
    else $error("accepted read did not start a lookup");

  a_scan_ends_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.scan_last) |=> (state_q == ST_IDLE && !result_valid_o))
    else $error("scan did not return to idle");

endmodule

`default_nettype wire

FILE: rtl/tdp_datapath.sv
// Datapath of the tile dot plotter: zoom register, tile memory with epoch tags,
// sweep counter and the dot scan counters. Depends on tdp_pkg.
`default_nettype none

module tdp_datapath #(
  parameter int unsigned TILE_SIZE = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tdp_pkg::ZOOM_W-1:0]  cfg_wdata_i,
  input  wire logic [tdp_pkg::COORD_W-1:0] x_pos_i,
  input  wire logic [tdp_pkg::COORD_W-1:0] y_pos_i,
  input  wire logic [tdp_pkg::PIX_W-1:0]   pixel_value_i,
  input  wire tdp_pkg::cmd_t               cmd_i,
  output tdp_pkg::status_t                 status_o,
  output logic [tdp_pkg::PIX_W-1:0]        read_value_o
);
  import tdp_pkg::*;

  // Only coordinates below 256 can ever be addressed
  localparam int unsigned SPAN   = (TILE_SIZE < 256) ? TILE_SIZE : 256;
  localparam int unsigned DEPTH  = SPAN * SPAN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned WORD_W = TAG_W + PIX_W;
  localparam int unsigned POS_W  = COORD_W + 2;

  logic [ZOOM_W-1:0]  zoom_q;
  logic [TAG_W-1:0]   tag_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [PIX_W-1:0]   pix_q;
  logic               draw_q, disk_q, center_ok_q;
  logic [OFS_W-1:0]   lo_q, hi_q, dx_q, dy_q;
  logic [RR_W-1:0]    rr_q;
  logic [WORD_W-1:0]  rd_q;

  logic [WORD_W-1:0]  tile_mem [DEPTH];

  shape_t             shape;
  logic               center_ok;
  logic signed [POS_W-1:0] px, py;
  logic               px_ok, py_ok;
  logic [2:0]         dxa, dya;
  logic [RR_W:0]      d2;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr, scan_addr, read_addr;
  logic [WORD_W-1:0]  mem_wdata;

  assign shape     = zoom_shape(zoom_q);
  assign center_ok = (32'(x_pos_i) < SPAN) && (32'(y_pos_i) < SPAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q  <= '0;
      tag_q   <= '0;
      sweep_q <= '0;
    end else begin
      if (cfg_we_i) zoom_q <= cfg_wdata_i;
      if (cmd_i.clear_bump) tag_q <= tag_q + TAG_W'(1);
      if (cmd_i.clear_sweep) begin
        tag_q   <= '0;
        sweep_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= status_o.sweep_last ? '0 : sweep_q + ADDR_W'(1);
      end
    end
  end

  // Item registers and scan counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_plot || cmd_i.load_read) begin
      x_q         <= x_pos_i;
      y_q         <= y_pos_i;
      pix_q       <= pixel_value_i;
      center_ok_q <= center_ok;
      draw_q      <= shape.draw && center_ok;
      disk_q      <= shape.disk;
      lo_q        <= shape.lo;
      hi_q        <= shape.hi;
      rr_q        <= shape.rr;
      dx_q        <= shape.lo;
      dy_q        <= shape.lo;
    end else if (cmd_i.scan_step) begin
      if (dx_q == hi_q) begin
        dx_q <= lo_q;
        dy_q <= dy_q + OFS_W'(1);
      end else begin
        dx_q <= dx_q + OFS_W'(1);
      end
    end
  end

  always_comb begin
    px    = $signed({2'b00, x_q}) + POS_W'($signed(dx_q));
    py    = $signed({2'b00, y_q}) + POS_W'($signed(dy_q));
    px_ok = !px[POS_W-1] && (px[POS_W-2:0] < (POS_W-1)'(SPAN));
    py_ok = !py[POS_W-1] && (py[POS_W-2:0] < (POS_W-1)'(SPAN));
    dxa   = 3'(dx_q[OFS_W-1] ? -dx_q : dx_q);
    dya   = 3'(dy_q[OFS_W-1] ? -dy_q : dy_q);
    d2    = {4'b0000, dxa} * {4'b0000, dxa} + {4'b0000, dya} * {4'b0000, dya};
    scan_addr = ADDR_W'(ADDR_W'(py[COORD_W-1:0]) * ADDR_W'(SPAN)
                        + ADDR_W'(px[COORD_W-1:0]));
    read_addr = ADDR_W'(ADDR_W'(y_q) * ADDR_W'(SPAN) + ADDR_W'(x_q));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = read_addr;
    mem_wdata = {tag_q, pix_q};
    if (cmd_i.sweep_step) begin
      mem_we    = 1'b1;
      mem_addr  = sweep_q;
      mem_wdata = '0;
    end else if (cmd_i.scan_step) begin
      mem_addr = scan_addr;
      mem_we   = draw_q && px_ok && py_ok && (!disk_q || d2 <= {1'b0, rr_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tile_mem[mem_addr] <= mem_wdata;
    if (cmd_i.read_issue) rd_q <= tile_mem[mem_addr];
  end

  // A stale tag means the pixel was cleared after it was written
  assign read_value_o = (center_ok_q && rd_q[WORD_W-1:PIX_W] == tag_q)
                        ? rd_q[PIX_W-1:0] : '0;

  assign status_o.epoch_full = (tag_q == '1);
  assign status_o.sweep_last = (32'(sweep_q) == DEPTH - 1);
  assign status_o.scan_last  = (dx_q == hi_q) && (dy_q == hi_q);

endmodule

`default_nettype wire

FILE: bench/tile_dot_plotter_unit_test.sv
// Self-checking bench for tile_dot_plotter_unit: directed table, then random traffic of all kinds.
// Keeps its own pixel tile and zoom copy, and checks each read transfer against it.
// Depends on tdp_pkg and tile_dot_plotter_unit.
`timescale 1ns / 100ps

module tile_dot_plotter_unit_test;
  import tdp_pkg::*;

  localparam int TILE        = 256;
  localparam int CYCLE_LIMIT = 1_200_000;
  // Longest plot is a radius-5 bounding box (121 pixels); settle a bit past it
  localparam int SETTLE      = 140;
  localparam int SCRIPT_LEN  = 34;
  localparam int REPORT_MAX  = 10;
  // The package leaves the fourth kind code unnamed; the unit drops it
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic             set_zoom;  // row writes zoom_level instead of sending an item
    logic [ZOOM_W-1:0] zoom;
    logic [KIND_W-1:0] kind;
    logic [7:0]       x;
    logic [7:0]       y;
    logic [PIX_W-1:0] v;
    logic             given;     // want holds a hand-typed read value
    logic [PIX_W-1:0] want;
  } script_row_t;

  typedef struct packed {
    logic             given;
    logic [PIX_W-1:0] val;
  } typed_read_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   kind_i        = '0;
  logic [COORD_W-1:0]  x_pos_i       = '0;
  logic [COORD_W-1:0]  y_pos_i       = '0;
  logic [PIX_W-1:0]    pixel_value_i = '0;
  logic                cfg_we_i      = 1'b0;
  logic [ZOOM_W-1:0]   cfg_wdata_i   = '0;
  logic                result_valid_o;
  logic [PIX_W-1:0]    read_value_o;

  tile_dot_plotter_unit #(.TILE_SIZE(TILE)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .pixel_value_i  (pixel_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow tile. A clear just advances the generation; a pixel whose stamp is
  // older than the current generation reads as zero. Keeps clears O(1).
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]  shadow_pix   [TILE*TILE];
  int unsigned       shadow_stamp [TILE*TILE];
  int unsigned       clear_gen    = 1;
  logic [ZOOM_W-1:0] zoom_q       = '0;

  logic [PIX_W-1:0]  pixel_q [$];   // read values still owed by the unit
  typed_read_t       typed_q [$];   // one entry per sent item, in send order

  int errors         = 0;
  int items_accepted = 0;
  int reads_checked  = 0;
  int clears_seen    = 0;
  int plots_seen     = 0;
  int dropped_seen   = 0;
  int zoom_writes    = 0;
  int cycle_count    = 0;

  logic start_on   = 1'b0;  // mirror of what start was last driven to
  int   burst_left = 0;

  initial begin
    for (int a = 0; a < TILE*TILE; a++) begin
      shadow_pix[a]   = '0;
      shadow_stamp[a] = 0;
    end
  end

  task automatic set_pixel(input int x, input int y, input logic [PIX_W-1:0] v);
    if (x >= 0 && x < TILE && y >= 0 && y < TILE) begin
      shadow_pix[y*TILE + x]   = v;
      shadow_stamp[y*TILE + x] = clear_gen;
    end
  endtask

  function automatic logic [PIX_W-1:0] pixel_at(input int x, input int y);
    if (x >= TILE || y >= TILE) return '0;
    if (shadow_stamp[y*TILE + x] != clear_gen) return '0;
    return shadow_pix[y*TILE + x];
  endfunction

  // Draw one dot into the shadow tile at the current zoom
  task automatic paint_dot(input int xc, input int yc, input logic [PIX_W-1:0] v);
    int r;
    if (xc >= TILE || yc >= TILE) return;
    if (zoom_q < 5'd8) return;
    if (zoom_q <= 5'd10) begin
      set_pixel(xc, yc, v);
      if (zoom_q == 5'd10) begin
        // set_pixel drops the off-tile column and row
        set_pixel(xc + 1, yc, v);
        set_pixel(xc, yc + 1, v);
        set_pixel(xc + 1, yc + 1, v);
      end
      return;
    end
    case (zoom_q)
      5'd11, 5'd12, 5'd13: r = 2;
      5'd14:               r = 3;
      5'd17:               r = 5;
      default:             r = 4;  // 15, 16 and everything past the table
    endcase
    for (int y = yc - r; y <= yc + r; y++)
      for (int x = xc - r; x <= xc + r; x++)
        if ((x - xc)*(x - xc) + (y - yc)*(y - yc) <= r*r) set_pixel(x, y, v);
  endtask

  task automatic flag(input string what, input int want, input int got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
               errors, cycle_count, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Bus watcher: sample everything at the rising edge, before the unit's own
  // updates land. Check the read transfer first, then fold in a config write
  // or an accepted item; a result can never belong to the item taken this edge.
  // ---------------------------------------------------------------------------
  typed_read_t     note;
  logic [PIX_W-1:0] want_pix;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d reads pending", cycle_count, pixel_q.size());
      $display("status: fail");
      $finish;
    end
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pixel_q.size() == 0) begin
          flag("read transfer with nothing pending", -1, int'(read_value_o));
        end else begin
          want_pix = pixel_q.pop_front();
          reads_checked++;
          if (read_value_o !== want_pix)
            flag("read_value", int'(want_pix), int'(read_value_o));
        end
      end
      if (cfg_we_i) zoom_q = cfg_wdata_i;
      if (start && !busy) begin
        note = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
        items_accepted++;
        case (kind_i)
          KIND_CLEAR: begin
            clear_gen++;
            clears_seen++;
          end
          KIND_PLOT: begin
            paint_dot(int'(x_pos_i), int'(y_pos_i), pixel_value_i);
            plots_seen++;
          end
          KIND_READ: pixel_q.push_back(note.given ? note.val
                                                  : pixel_at(int'(x_pos_i), int'(y_pos_i)));
          default: dropped_seen++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic drop_start();
    if (start_on) begin
      start    <= 1'b0;
      start_on  = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 30);
    return $urandom_range(31, 150);
  endfunction

  // Present one item, hold it until taken, then either keep start high for
  // the next item of the burst or drop it for a random gap
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [7:0] x,
                           input logic [7:0] y, input logic [PIX_W-1:0] v,
                           input logic given, input logic [PIX_W-1:0] typed);
    typed_q.push_back('{given, typed});
    kind_i        <= k;
    x_pos_i       <= x;
    y_pos_i       <= y;
    pixel_value_i <= v;
    start         <= 1'b1;
    start_on       = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (burst_left == 0) begin
      drop_start();
      repeat (pick_gap()) @(posedge clk_i);
      burst_left = $urandom_range(0, 3) != 0 ? $urandom_range(0, 6) : $urandom_range(15, 45);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every owed read has been transferred
  task automatic drain_reads();
    drop_start();
    do @(posedge clk_i); while (pixel_q.size() != 0);
  endtask

  // Write zoom_level only with the unit idle: drain reads, let a trailing
  // plot or clear finish, then wait out busy
  task automatic write_zoom(input logic [ZOOM_W-1:0] z);
    drain_reads();
    repeat (SETTLE) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= z;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    zoom_writes++;
  endtask

  // Corners and edge-adjacent coordinates turn up often to exercise clipping
  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly plot-then-read-nearby sequences so reads land on drawn pixels;
  // the rest is stray reads, clears, dropped kinds and an occasional drain
  task automatic run_traffic(input int count);
    int         sent;
    int         pick;
    int         reads;
    logic [7:0] cx;
    logic [7:0] cy;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        cx = pick_coord();
        cy = pick_coord();
        send_item(KIND_PLOT, cx, cy, 8'($urandom), 1'b0, '0);
        reads = $urandom_range(1, 3);
        for (int j = 0; j < reads; j++)
          send_item(KIND_READ, 8'(cx + $urandom_range(0, 12) - 6),
                    8'(cy + $urandom_range(0, 12) - 6), 8'($urandom), 1'b0, '0);
        sent += 1 + reads;
      end else if (pick < 85) begin
        send_item(KIND_READ, pick_coord(), pick_coord(), 8'($urandom), 1'b0, '0);
        sent++;
      end else if (pick < 90) begin
        send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        sent++;
      end else if (pick < 96) begin
        send_item(KIND_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      end else begin
        drain_reads();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Hand-typed reads are the ones obvious at a glance; the
  // rest take their value from the shadow tile.
  // ---------------------------------------------------------------------------
  script_row_t script [0:SCRIPT_LEN-1] = '{
    // Reset leaves the tile empty, at both corners
    '{1'b0, 5'd0,  KIND_READ,  8'd0,   8'd0,   8'h00, 1'b1, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd255, 8'd255, 8'h00, 1'b1, 8'h00},
    // Levels below 8 draw nothing
    '{1'b1, 5'd0,  KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd40,  8'd40,  8'hAA, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd40,  8'd40,  8'h00, 1'b1, 8'h00},
    '{1'b1, 5'd7,  KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd41,  8'd41,  8'h55, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd41,  8'd41,  8'h00, 1'b1, 8'h00},
    // Single pixel at the far corner and the origin, extreme values
    '{1'b1, 5'd8,  KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd255, 8'd255, 8'hFF, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd255, 8'd255, 8'h00, 1'b1, 8'hFF},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd0,   8'd0,   8'h01, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd0,   8'd0,   8'h00, 1'b1, 8'h01},
    // 2x2 block losing its right column, then its lower row
    '{1'b1, 5'd10, KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd255, 8'd0,   8'h5A, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd255, 8'd1,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd0,   8'd1,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd0,   8'd255, 8'hA5, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd1,   8'd255, 8'h00, 1'b0, 8'h00},
    // Radius-5 disk clipped at the origin corner; rim and just outside
    '{1'b1, 5'd17, KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd0,   8'd0,   8'h3C, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd4,   8'd3,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd5,   8'd1,   8'h00, 1'b0, 8'h00},
    // Top of the register range falls back to radius 4
    '{1'b1, 5'd31, KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_PLOT,  8'd128, 8'd128, 8'hC3, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd132, 8'd128, 8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd132, 8'd129, 8'h00, 1'b0, 8'h00},
    '{1'b1, 5'd20, KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    // Unused kind changes nothing
    '{1'b0, 5'd0,  KIND_SPARE, 8'd255, 8'd255, 8'h77, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd255, 8'd255, 8'h00, 1'b1, 8'hFF},
    // Clear empties everything
    '{1'b0, 5'd0,  KIND_PLOT,  8'd200, 8'd60,  8'h80, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd200, 8'd60,  8'h00, 1'b1, 8'h00},
    '{1'b0, 5'd0,  KIND_READ,  8'd128, 8'd128, 8'h00, 1'b1, 8'h00}
  };

  // Phase zoom settings: every shape class, both register extremes, one random
  logic [ZOOM_W-1:0] phase_zoom [0:13] = '{
    5'd8, 5'd10, 5'd11, 5'd14, 5'd17, 5'd0, 5'd20, 5'd31,
    5'd9, 5'd15, 5'd13, 5'd16, 5'd18, 5'd12
  };

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].set_zoom)
        write_zoom(script[i].zoom);
      else
        send_item(script[i].kind, script[i].x, script[i].y, script[i].v,
                  script[i].given, script[i].want);
    end

    // Random traffic over the zoom table; last phase picks any register value
    foreach (phase_zoom[p]) begin
      write_zoom(p == 13 ? 5'($urandom) : phase_zoom[p]);
      run_traffic(10);
    end

    // Run the clear count past 256 so the epoch wrap and its sweep get hit;
    // drop in a dot and reads now and then to prove stale pixels stay hidden
    write_zoom(5'd14);
    for (int i = 0; i < 260; i++) begin
      send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      if (i % 13 == 0) begin
        send_item(KIND_PLOT, pick_coord(), pick_coord(), 8'($urandom), 1'b0, '0);
        send_item(KIND_READ, pick_coord(), pick_coord(), 8'($urandom), 1'b0, '0);
      end
      if (i % 70 == 0) drain_reads();
    end
    write_zoom(5'd17);
    run_traffic(20);

    drop_start();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (pixel_q.size() != 0) flag("reads never transferred", 0, pixel_q.size());

    $display("covered %0d items: %0d plots, %0d clears, %0d dropped kinds, %0d reads checked",
             items_accepted, plots_seen, clears_seen, dropped_seen, reads_checked);
    $display("zoom written %0d times, %0d failures, %0d cycles", zoom_writes, errors, cycle_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
